[hdl/bsrs_pkg.sv]
package bsrs_pkg;

   // Operation codes
   localparam logic [2:0] OP_PUSH  = 3'd0;
   localparam logic [2:0] OP_POP   = 3'd1;
   localparam logic [2:0] OP_CLEAR = 3'd2;
   localparam logic [2:0] OP_PEEK  = 3'd3;
   localparam logic [2:0] OP_SCAN  = 3'd4;

   // Status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Cell commands
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_PUSH   = 2'd1;
   localparam logic [1:0] CELL_POP    = 2'd2;
   localparam logic [1:0] CELL_ROTATE = 2'd3;

   typedef struct packed {
      logic [63:0]        name;
      logic [7:0]         kind;
      logic signed [31:0] value;
   } rec_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       wrap;
   } cell_ctl_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic [63:0]        entry_name;
      logic [7:0]         entry_kind;
      logic signed [31:0] entry_value;
      logic signed [31:0] range_low;
      logic signed [31:0] range_high;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               item_valid;
      logic [63:0]        item_name;
      logic [7:0]         item_kind;
      logic signed [31:0] item_value;
      logic               last;
   } rsp_type;

   function automatic rsp_type make_status(input logic [1:0] status, input logic last);
      rsp_type r;
      r            = '0;
      r.status     = status;
      r.last       = last;
      return r;
   endfunction

   function automatic rsp_type make_record(input rec_type rec, input logic last);
      rsp_type r;
      r.status     = STATUS_OK;
      r.item_valid = 1'b1;
      r.item_name  = rec.name;
      r.item_kind  = rec.kind;
      r.item_value = rec.value;
      r.last       = last;
      return r;
   endfunction

endpackage

[hdl/bsrs_cell.sv]
module bsrs_cell (
   input  logic                  clock,
   input  bsrs_pkg::cell_ctl_type ctl,
   input  bsrs_pkg::rec_type     above_rec,
   input  bsrs_pkg::rec_type     below_rec,
   input  bsrs_pkg::rec_type     wrap_rec,
   output bsrs_pkg::rec_type     rec
);

   bsrs_pkg::rec_type rec_ff;
   bsrs_pkg::rec_type rec_in;

   // Pick the next record: hold, take from above, take from below, or wrap
   always_comb begin
      unique case (ctl.cmd)
         bsrs_pkg::CELL_HOLD:   rec_in = rec_ff;
         bsrs_pkg::CELL_PUSH:   rec_in = above_rec;
         bsrs_pkg::CELL_POP:    rec_in = below_rec;
         bsrs_pkg::CELL_ROTATE: rec_in = ctl.wrap ? wrap_rec : below_rec;
         default:               rec_in = rec_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

endmodule

[hdl/bounded_stack_range_scan_core.sv]
// Channel | Ports                          | Direction | Transfer when
// req     | req_valid, req_stall, req_data | in        | req_valid && !req_stall
// rsp     | rsp_valid, rsp_stall, rsp_data | out       | rsp_valid && !rsp_stall
//
// Records live in a chain of STACK_DEPTH cells, the top in cell 0; push and pop move
// every cell one place, and scan moves every cell one place per cycle while the result
// is not stalled. Push, pop, clear and peek each give one registered response. In a
// range scan the chain rotates one record past cell 0 per cycle, then the closing
// status goes out. One request is in flight at a time. Reset (synchronous) empties the
// stack. A stalled result holds the output register and freezes the scan.
module bounded_stack_range_scan_core #(
   parameter int STACK_DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bsrs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bsrs_pkg::rsp_type rsp_data
);

   localparam int OCC_W = $clog2(STACK_DEPTH + 1);

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_SCAN = 1'b1;

   logic                     state_ff, state_in;
   logic [OCC_W-1:0]         occ_ff, occ_in;
   logic [OCC_W-1:0]         left_ff, left_in;
   logic signed [31:0]       low_ff, low_in;
   logic signed [31:0]       high_ff, high_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   bsrs_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                     slot_free;
   logic                     req_fire;
   logic [1:0]               cell_cmd;
   bsrs_pkg::rec_type        cell_rec [STACK_DEPTH];
   bsrs_pkg::rec_type        push_rec;
   bsrs_pkg::rec_type        top_rec;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != STATE_IDLE) || !slot_free;
   assign req_fire  = req_valid && !req_stall;
   assign top_rec   = cell_rec[0];

   assign push_rec.name  = req_data.entry_name;
   assign push_rec.kind  = req_data.entry_kind;
   assign push_rec.value = req_data.entry_value;

   // Cell chain: cell 0 is the top of stack
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      bsrs_pkg::cell_ctl_type ctl;
      bsrs_pkg::rec_type      above_rec;
      bsrs_pkg::rec_type      below_rec;

      assign ctl.cmd  = cell_cmd;
      assign ctl.wrap = (occ_ff == OCC_W'(i + 1));

      if (i == 0) begin : g_top
         assign above_rec = push_rec;
      end else begin : g_mid
         assign above_rec = cell_rec[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign below_rec = cell_rec[i];
      end else begin : g_inner
         assign below_rec = cell_rec[i+1];
      end

      bsrs_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .above_rec (above_rec),
         .below_rec (below_rec),
         .wrap_rec  (top_rec),
         .rec       (cell_rec[i])
      );
   end

   // Sequence operations and the scan
   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      left_in      = left_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cell_cmd     = bsrs_pkg::CELL_HOLD;

      if (state_ff == STATE_IDLE) begin
         if (req_fire) begin
            rsp_valid_in = 1'b1;
            unique case (req_data.operation)
               bsrs_pkg::OP_PUSH: begin
                  if (occ_ff == OCC_W'(STACK_DEPTH)) begin
                     rsp_data_in = bsrs_pkg::make_status(bsrs_pkg::STATUS_FULL, 1'b1);
                  end else begin
                     cell_cmd    = bsrs_pkg::CELL_PUSH;
                     occ_in      = occ_ff + OCC_W'(1);
                     rsp_data_in = bsrs_pkg::make_status(bsrs_pkg::STATUS_OK, 1'b1);
                  end
               end
               bsrs_pkg::OP_POP: begin
                  if (occ_ff == '0) begin
                     rsp_data_in = bsrs_pkg::make_status(bsrs_pkg::STATUS_EMPTY, 1'b1);
                  end else begin
                     cell_cmd    = bsrs_pkg::CELL_POP;
                     occ_in      = occ_ff - OCC_W'(1);
                     rsp_data_in = bsrs_pkg::make_record(top_rec, 1'b1);
                  end
               end
               bsrs_pkg::OP_CLEAR: begin
                  occ_in      = '0;
                  rsp_data_in = bsrs_pkg::make_status(bsrs_pkg::STATUS_OK, 1'b1);
               end
               bsrs_pkg::OP_PEEK: begin
                  if (occ_ff == '0) begin
                     rsp_data_in = bsrs_pkg::make_status(bsrs_pkg::STATUS_EMPTY, 1'b1);
                  end else begin
                     rsp_data_in = bsrs_pkg::make_record(top_rec, 1'b1);
                  end
               end
               bsrs_pkg::OP_SCAN: begin
                  if (occ_ff == '0) begin
                     rsp_data_in = bsrs_pkg::make_status(bsrs_pkg::STATUS_EMPTY, 1'b1);
                  end else begin
                     // Open the scan; records are emitted from the SCAN state
                     rsp_valid_in = 1'b0;
                     state_in     = STATE_SCAN;
                     left_in      = occ_ff;
                     low_in       = req_data.range_low;
                     high_in      = req_data.range_high;
                  end
               end
               default: begin
                  rsp_data_in = bsrs_pkg::make_status(bsrs_pkg::STATUS_OK, 1'b1);
               end
            endcase
         end
      end else if (slot_free) begin
         if (left_ff != '0) begin
            // Rotate one record past the top and emit it when in range
            cell_cmd     = bsrs_pkg::CELL_ROTATE;
            left_in      = left_ff - OCC_W'(1);
            rsp_valid_in = (top_rec.value > low_ff) && (top_rec.value < high_ff);
            rsp_data_in  = bsrs_pkg::make_record(top_rec, 1'b0);
         end else begin
            // Close the scan with a status-only transfer
            rsp_valid_in = 1'b1;
            rsp_data_in  = bsrs_pkg::make_status(bsrs_pkg::STATUS_OK, 1'b1);
            state_in     = STATE_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         occ_ff       <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff      <= low_in;
      high_ff     <= high_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
